// ===== rtl/core/cbs_pkg.sv =====
`timescale 1ns / 1ps

package cbs_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int MAX_STEPS       = 64;
	localparam int STEP_W          = 7;
	localparam int SLOT_W          = 6;
	localparam int T_W             = 16;
	localparam int U_W             = 17;
	// Bernstein weights are at most 2^48 (u^3 at t = 0)
	localparam int WGT_W           = 49;
	localparam int WGT_LO_W        = 24;
	localparam int FRAC_SHIFT      = 48;
	localparam logic [U_W-1:0] T_ONE = 17'h10000;

	// floor(65536 / steps) kept to 16 bits, indexed by steps - 1
	localparam logic [T_W-1:0] RECIP_TBL [64] = '{
		16'd0,     16'd32768, 16'd21845, 16'd16384, 16'd13107, 16'd10922, 16'd9362,  16'd8192,
		16'd7281,  16'd6553,  16'd5957,  16'd5461,  16'd5041,  16'd4681,  16'd4369,  16'd4096,
		16'd3855,  16'd3640,  16'd3449,  16'd3276,  16'd3120,  16'd2978,  16'd2849,  16'd2730,
		16'd2621,  16'd2520,  16'd2427,  16'd2340,  16'd2259,  16'd2184,  16'd2114,  16'd2048,
		16'd1985,  16'd1927,  16'd1872,  16'd1820,  16'd1771,  16'd1724,  16'd1680,  16'd1638,
		16'd1598,  16'd1560,  16'd1524,  16'd1489,  16'd1456,  16'd1424,  16'd1394,  16'd1365,
		16'd1337,  16'd1310,  16'd1285,  16'd1260,  16'd1236,  16'd1213,  16'd1191,  16'd1170,
		16'd1149,  16'd1129,  16'd1110,  16'd1092,  16'd1074,  16'd1057,  16'd1040,  16'd1024
	};

	typedef struct packed {
		logic              load;
		logic              issue;
		logic [T_W-1:0]    t;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic front_empty;
		logic adv;
	} status_t;

endpackage

// ===== rtl/core/cbs_ctrl.sv =====
`timescale 1ns / 1ps

module cbs_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cbs_pkg::STEP_W-1:0]    step_count,
	input  cbs_pkg::status_t              status,
	output cbs_pkg::cmd_t                 cmd
);

	typedef enum logic {
		IDLE,
		RUN
	} state_t;

	state_t                        state_q;
	logic [cbs_pkg::T_W-1:0]       t_q;
	logic [cbs_pkg::T_W-1:0]       inc_q;
	logic [cbs_pkg::STEP_W-1:0]    left_q;
	logic [cbs_pkg::STEP_W-1:0]    steps_sat;
	logic [cbs_pkg::STEP_W-1:0]    steps_m1;
	logic [cbs_pkg::STEP_W-1:0]    left_m1;
	logic                          accept;

	assign in_ready  = (state_q == IDLE) && status.front_empty;
	assign accept    = in_valid && in_ready;
	assign steps_sat = (step_count > cbs_pkg::STEP_W'(cbs_pkg::MAX_STEPS))
		? cbs_pkg::STEP_W'(cbs_pkg::MAX_STEPS) : step_count;
	assign steps_m1  = steps_sat - cbs_pkg::STEP_W'(1);
	assign left_m1   = left_q - cbs_pkg::STEP_W'(1);

	assign cmd.load  = accept;
	assign cmd.issue = (state_q == RUN) && status.adv;
	assign cmd.t     = t_q;
	assign cmd.slot  = left_m1[cbs_pkg::SLOT_W-1:0];
	assign cmd.last  = (left_q == cbs_pkg::STEP_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			t_q     <= '0;
			inc_q   <= '0;
			left_q  <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					// a zero step count is taken and dropped
					if (accept && (step_count != '0)) begin
						inc_q   <= cbs_pkg::RECIP_TBL[steps_m1[cbs_pkg::SLOT_W-1:0]];
						t_q     <= '0;
						left_q  <= steps_sat;
						state_q <= RUN;
					end
				end
				RUN: begin
					if (cmd.issue) begin
						t_q    <= t_q + inc_q;
						left_q <= left_m1;
						if (cmd.last) begin
							state_q <= IDLE;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/cbs_datapath.sv =====
`timescale 1ns / 1ps

module cbs_datapath #(
	parameter int COORD_WIDTH = cbs_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [COORD_WIDTH-1:0]     start_x,
	input  logic signed [COORD_WIDTH-1:0]     start_y,
	input  logic signed [COORD_WIDTH-1:0]     ctrl_a_x,
	input  logic signed [COORD_WIDTH-1:0]     ctrl_a_y,
	input  logic signed [COORD_WIDTH-1:0]     ctrl_b_x,
	input  logic signed [COORD_WIDTH-1:0]     ctrl_b_y,
	input  logic signed [COORD_WIDTH-1:0]     end_x,
	input  logic signed [COORD_WIDTH-1:0]     end_y,
	input  cbs_pkg::cmd_t                     cmd,
	output cbs_pkg::status_t                  status,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [COORD_WIDTH-1:0]     curve_x,
	output logic signed [COORD_WIDTH-1:0]     curve_y,
	output logic [cbs_pkg::SLOT_W-1:0]        slot,
	output logic                              last
);

	localparam int CW    = COORD_WIDTH;
	localparam int T_W   = cbs_pkg::T_W;
	localparam int U_W   = cbs_pkg::U_W;
	localparam int W_W   = cbs_pkg::WGT_W;
	localparam int LO_W  = cbs_pkg::WGT_LO_W;
	localparam int HI_W  = W_W - LO_W;
	localparam int PLO_W = CW + LO_W + 1;
	localparam int PHI_W = CW + HI_W + 1;
	localparam int ACC_W = CW + W_W + 2;

	typedef struct packed {
		logic [cbs_pkg::SLOT_W-1:0] slot;
		logic                       last;
	} meta_t;

	// control points, axis 0 = x, axis 1 = y
	logic signed [CW-1:0]     coord_q [2][4];

	logic                     adv;
	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	meta_t                    meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6, meta_s7;

	logic [T_W-1:0]           t_s1;
	logic [U_W-1:0]           u_s1;
	logic [2*T_W-1:0]         t2_s1;
	logic [2*T_W:0]           tu_s1;
	logic [2*T_W:0]           u2_s1;

	logic [3*T_W-1:0]         t3_s2;
	logic [W_W-1:0]           t2u_s2;
	logic [W_W-1:0]           tu2_s2;
	logic [W_W-1:0]           u3_s2;

	logic [W_W-1:0]           w_s3 [4];

	logic signed [PLO_W-1:0]  plo_s4 [2][4];
	logic signed [PHI_W-1:0]  phi_s4 [2][4];
	logic signed [ACC_W-1:0]  term_s5 [2][4];
	logic signed [ACC_W-1:0]  pair_s6 [2][2];
	logic signed [CW-1:0]     curve_s7 [2];

	logic [U_W-1:0]           u_now;
	logic [2*T_W-1:0]         t2_full;
	logic [T_W+U_W-1:0]       tu_full;
	logic [2*U_W-1:0]         u2_full;
	logic [3*T_W-1:0]         t3_full;
	logic [2*T_W+U_W-1:0]     t2u_full;
	logic [2*T_W+1+U_W-1:0]   tu2_full;
	logic [2*T_W+1+U_W-1:0]   u3_full;
	logic [W_W+1:0]           w1_full;
	logic [W_W+1:0]           w2_full;
	logic signed [ACC_W-1:0]  total [2];

	assign adv = !vld_s7 || out_ready;
	assign status.adv = adv;
	// new control points may load once no point still needs the old ones
	assign status.front_empty = !(vld_s1 || vld_s2 || vld_s3);

	assign u_now    = cbs_pkg::T_ONE - {1'b0, cmd.t};
	assign t2_full  = cmd.t * cmd.t;
	assign tu_full  = cmd.t * u_now;
	assign u2_full  = u_now * u_now;
	assign t3_full  = t2_s1 * t_s1;
	assign t2u_full = t2_s1 * u_s1;
	assign tu2_full = tu_s1 * u_s1;
	assign u3_full  = u2_s1 * u_s1;
	assign w1_full  = {1'b0, tu2_s2, 1'b0} + {2'b00, tu2_s2};
	assign w2_full  = {1'b0, t2u_s2, 1'b0} + {2'b00, t2u_s2};

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			total[a] = pair_s6[a][0] + pair_s6[a][1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			coord_q[0][0] <= start_x;
			coord_q[1][0] <= start_y;
			coord_q[0][1] <= ctrl_a_x;
			coord_q[1][1] <= ctrl_a_y;
			coord_q[0][2] <= ctrl_b_x;
			coord_q[1][2] <= ctrl_b_y;
			coord_q[0][3] <= end_x;
			coord_q[1][3] <= end_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= '{slot: cmd.slot, last: cmd.last};
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
			meta_s6 <= meta_s5;
			meta_s7 <= meta_s6;

			// powers of t and u = 1 - t
			t_s1  <= cmd.t;
			u_s1  <= u_now;
			t2_s1 <= t2_full;
			tu_s1 <= tu_full[2*T_W:0];
			u2_s1 <= u2_full[2*T_W:0];

			t3_s2  <= t3_full;
			t2u_s2 <= t2u_full[W_W-1:0];
			tu2_s2 <= tu2_full[W_W-1:0];
			u3_s2  <= u3_full[W_W-1:0];

			w_s3[0] <= u3_s2;
			w_s3[1] <= w1_full[W_W-1:0];
			w_s3[2] <= w2_full[W_W-1:0];
			w_s3[3] <= W_W'(t3_s2);

			// weight split in two halves to keep each multiplier narrow
			for (int a = 0; a < 2; a++) begin
				for (int i = 0; i < 4; i++) begin
					plo_s4[a][i] <= coord_q[a][i] * $signed({1'b0, w_s3[i][LO_W-1:0]});
					phi_s4[a][i] <= coord_q[a][i] * $signed({1'b0, w_s3[i][W_W-1:LO_W]});
					term_s5[a][i] <= (ACC_W'(phi_s4[a][i]) <<< LO_W) + ACC_W'(plo_s4[a][i]);
				end
				pair_s6[a][0] <= term_s5[a][0] + term_s5[a][1];
				pair_s6[a][1] <= term_s5[a][2] + term_s5[a][3];
				// weights sum to 2^48, so the shifted sum always fits
				curve_s7[a] <= total[a][cbs_pkg::FRAC_SHIFT +: CW];
			end
		end
	end

	assign out_valid = vld_s7;
	assign curve_x   = curve_s7[0];
	assign curve_y   = curve_s7[1];
	assign slot      = meta_s7.slot;
	assign last      = meta_s7.last;

endmodule

// ===== rtl/core/cubic_bezier_sampler.sv =====
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// input    in_valid/in_ready    start_x/y, ctrl_a_x/y, ctrl_b_x/y, end_x/y, step_count
// output   out_valid/out_ready  curve_x, curve_y, slot, last
//
// One curve point leaves per cycle unless out_ready stalls the output.
// The next input is taken once the last point has cleared the weight stages s1 to s3,
// so a new curve can enter while the last points of the previous one are in s4 to s7.
// The step increment comes from a 64-entry reciprocal table, no divider.
// Output stalls freeze the whole 7-stage pipeline and the point sequencer.
// arst_n clears the sequencer and all pipeline valid bits.

module cubic_bezier_sampler #(
	parameter int COORD_WIDTH = cbs_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [COORD_WIDTH-1:0]     start_x,
	input  logic signed [COORD_WIDTH-1:0]     start_y,
	input  logic signed [COORD_WIDTH-1:0]     ctrl_a_x,
	input  logic signed [COORD_WIDTH-1:0]     ctrl_a_y,
	input  logic signed [COORD_WIDTH-1:0]     ctrl_b_x,
	input  logic signed [COORD_WIDTH-1:0]     ctrl_b_y,
	input  logic signed [COORD_WIDTH-1:0]     end_x,
	input  logic signed [COORD_WIDTH-1:0]     end_y,
	input  logic [cbs_pkg::STEP_W-1:0]        step_count,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [COORD_WIDTH-1:0]     curve_x,
	output logic signed [COORD_WIDTH-1:0]     curve_y,
	output logic [cbs_pkg::SLOT_W-1:0]        slot,
	output logic                              last
);

	cbs_pkg::cmd_t    cmd;
	cbs_pkg::status_t status;

	cbs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.step_count (step_count),
		.status     (status),
		.cmd        (cmd)
	);

	cbs_datapath #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_x   (start_x),
		.start_y   (start_y),
		.ctrl_a_x  (ctrl_a_x),
		.ctrl_a_y  (ctrl_a_y),
		.ctrl_b_x  (ctrl_b_x),
		.ctrl_b_y  (ctrl_b_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.curve_x   (curve_x),
		.curve_y   (curve_y),
		.slot      (slot),
		.last      (last)
	);

endmodule
